/* rtl/ktx_pkg.sv */
// ----------------------------------------------------------------------------
// ktx_pkg: shared types and constants of the ktx1 container parser
// holds the result record, the queue depth and the gl code table
// ----------------------------------------------------------------------------
package ktx_pkg;

  localparam int unsigned DEF_MAX_LEVELS    = 24;
  localparam int unsigned DEF_MAX_DIMENSION = 65536;
  localparam int unsigned QDEPTH            = 4;
  localparam int unsigned QAW               = 2;

  localparam logic [2:0] K_DESC  = 3'd0;
  localparam logic [2:0] K_PIXEL = 3'd1;
  localparam logic [2:0] K_RAW   = 3'd2;
  localparam logic [2:0] K_DONE  = 3'd3;
  localparam logic [2:0] K_ERROR = 3'd4;

  localparam logic [2:0] E_SHORT  = 3'd0;
  localparam logic [2:0] E_ZERO   = 3'd1;
  localparam logic [2:0] E_NOT2D  = 3'd2;
  localparam logic [2:0] E_IMPL   = 3'd3;
  localparam logic [2:0] E_UNSUP  = 3'd4;
  localparam logic [2:0] E_ICUT   = 3'd5;
  localparam logic [2:0] E_DCUT   = 3'd6;
  localparam logic [2:0] E_LSHORT = 3'd7;

  localparam logic [2:0] M_RGBA8 = 3'd0;
  localparam logic [2:0] M_BGRA8 = 3'd1;
  localparam logic [2:0] M_RGB8  = 3'd2;
  localparam logic [2:0] M_F16   = 3'd3;
  localparam logic [2:0] M_F32   = 3'd4;
  localparam logic [2:0] M_BC7   = 3'd5;
  localparam logic [2:0] M_BC6H  = 3'd6;
  localparam logic [2:0] M_BCDEC = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  level_index;
    logic [16:0] level_width;
    logic [16:0] level_height;
    logic [2:0]  mode;
    logic [2:0]  bc_kind;
    logic [31:0] data_word;
    logic [2:0]  error_code;
    logic        last;
  } ktx_res_t;

  // up to two results per byte
  typedef struct packed {
    logic     v0;
    logic     v1;
    ktx_res_t r0;
    ktx_res_t r1;
  } ktx_pair_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] mode;
    logic [2:0] bc;
  } ktx_cls_t;

  function automatic ktx_cls_t ktx_classify(input logic [31:0] t, input logic [31:0] f,
                                            input logic [31:0] i);
    ktx_cls_t c;
    c = '0;
    if (t == 32'h0) begin
      c.ok = 1'b1;
      c.mode = M_BCDEC;
      case (i)
        32'h83F0, 32'h83F1, 32'h8C4C, 32'h8C4D: c.bc = 3'd0;
        32'h83F2, 32'h8C4E: c.bc = 3'd1;
        32'h83F3, 32'h8C4F: c.bc = 3'd2;
        32'h8DBB, 32'h8DBC: c.bc = 3'd3;
        32'h8DBD, 32'h8DBE: c.bc = 3'd4;
        32'h8E8C, 32'h8E8D: c.mode = M_BC7;
        32'h8E8E, 32'h8E8F: c.mode = M_BC6H;
        default: c.ok = 1'b0;
      endcase
    end else if (t == 32'h1401) begin
      c.ok = 1'b1;
      if (f == 32'h80E1) c.mode = M_BGRA8;
      else if (f == 32'h1908 || i == 32'h8058 || i == 32'h8C43) c.mode = M_RGBA8;
      else if (f == 32'h1907 || i == 32'h8051 || i == 32'h8C41) c.mode = M_RGB8;
      else c.ok = 1'b0;
    end else if (t == 32'h140B && (f == 32'h1908 || i == 32'h881A)) begin
      c.ok = 1'b1;
      c.mode = M_F16;
    end else if (t == 32'h1406 && (f == 32'h1908 || i == 32'h8814)) begin
      c.ok = 1'b1;
      c.mode = M_F32;
    end
    return c;
  endfunction

  function automatic logic [31:0] ktx_swap(input logic [31:0] w, input logic be);
    return be ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
  endfunction

endpackage

/* rtl/ktx_front.sv */
// ----------------------------------------------------------------------------
// ktx_front: byte parser of the ktx1 container
// tracks header, skip, index and data phases and builds the results of a byte
// ----------------------------------------------------------------------------
module ktx_front import ktx_pkg::*; #(
  parameter int unsigned MAX_LEVELS    = DEF_MAX_LEVELS,
  parameter int unsigned MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] file_length,
  input  logic        go,
  input  logic [7:0]  byte_in,
  input  logic        end_of_file,
  output logic        busy,
  output ktx_pair_t   pair
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_INDEX  = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_HALT   = 3'd4;
  localparam logic [2:0] PH_NEED   = 3'd5;

  localparam logic [17:0] DIM_LIM = 18'(MAX_DIMENSION);
  localparam logic [5:0]  LVL_LIM = 6'(MAX_LEVELS);

  logic [2:0]  phase_r, phase_nxt;
  logic [32:0] offs_r, offs_nxt;
  logic [31:0] wasm_r, wasm_nxt;
  logic [5:0]  hb_r, hb_nxt;
  logic [1:0]  wb_r, wb_nxt;
  logic        be_r, be_nxt;
  logic [31:0] gt_r, gt_nxt, gf_r, gf_nxt, gi_r, gi_nxt;
  logic [16:0] bw_r, bw_nxt, bh_r, bh_nxt;
  logic [5:0]  mips_r, mips_nxt;
  logic [31:0] kvl_r, kvl_nxt;
  logic        n2d_r, n2d_nxt;
  logic [4:0]  lvl_r, lvl_nxt;
  logic [2:0]  mode_r, mode_nxt, bc_r, bc_nxt;
  logic [31:0] isz_r, isz_nxt;
  logic [31:0] left_r, left_nxt;
  logic [18:0] rpos_r, rpos_nxt;
  logic [1:0]  pk_r, pk_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [16:0] lw_r, lh_r;
  logic [18:0] act_r, stride_r;
  logic [35:0] need_r;
  logic [1:0]  needst_r, needst_nxt;
  logic [19:0] pa_r, pb_r;

  ktx_pair_t   pr;

  // level size: computed in a short sequence after the level index advances
  function automatic logic [16:0] ldim(input logic [16:0] b, input logic [4:0] l);
    logic [16:0] v;
    v = b >> l;
    return (v == 17'd0) ? 17'd1 : v;
  endfunction

  always_ff @(posedge clk) begin
    lw_r <= ldim(bw_r, lvl_r);
    lh_r <= ldim(bh_r, lvl_r);
    case (mode_r)
      M_RGB8: act_r <= 19'({2'b0, lw_r} * 3);
      default: act_r <= {lw_r, 2'b00};
    endcase
    stride_r <= (act_r + 19'd3) & ~19'd3;
    case (mode_r)
      M_RGBA8, M_BGRA8, M_RGB8: begin
        pa_r <= {1'b0, stride_r};
        pb_r <= {3'b0, lh_r};
      end
      M_F16: begin
        pa_r <= {lw_r, 3'b000};
        pb_r <= {3'b0, lh_r};
      end
      M_F32: begin
        pa_r <= {lw_r[15:0], 4'b0000};
        pb_r <= {3'b0, lh_r};
      end
      M_BCDEC: begin
        pa_r <= 20'((18'(lw_r) + 18'd3) >> 2) << ((bc_r == 3'd0 || bc_r == 3'd3) ? 3 : 4);
        pb_r <= 20'((18'(lh_r) + 18'd3) >> 2);
      end
      default: begin
        pa_r <= '0;
        pb_r <= '0;
      end
    endcase
    need_r <= 36'(pa_r * pb_r);
  end

  assign busy = (phase_r == PH_NEED);
  assign pair = pr;

  always_comb begin
    logic [31:0] w, raw, p;
    logic [5:0]  hb;
    logic        fin, tmp;
    logic [1:0]  n;
    logic [31:0] used;
    logic [1:0]  pad;
    ktx_res_t    rr;
    ktx_cls_t    cls;
    logic [5:0]  mc;
    logic [16:0] bh;
    phase_nxt = phase_r;  offs_nxt = offs_r;  wasm_nxt = wasm_r;  hb_nxt = hb_r;
    wb_nxt = wb_r;  be_nxt = be_r;  gt_nxt = gt_r;  gf_nxt = gf_r;  gi_nxt = gi_r;
    bw_nxt = bw_r;  bh_nxt = bh_r;  mips_nxt = mips_r;  kvl_nxt = kvl_r;
    n2d_nxt = n2d_r;  lvl_nxt = lvl_r;  mode_nxt = mode_r;  bc_nxt = bc_r;
    isz_nxt = isz_r;  left_nxt = left_r;  rpos_nxt = rpos_r;  pk_nxt = pk_r;
    pix_nxt = pix_r;  skip_nxt = skip_r;  needst_nxt = needst_r;
    pr = '0;  n = 2'd0;  fin = 1'b0;
    w = '0;  raw = '0;  p = '0;  hb = '0;  tmp = 1'b0;  used = '0;  pad = '0;
    cls = '0;  mc = '0;  bh = '0;
    rr = '0;
    rr.level_index = lvl_r;
    rr.level_width = lw_r;
    rr.level_height = lh_r;
    rr.mode = mode_r;
    rr.bc_kind = (mode_r == M_BCDEC) ? bc_r : 3'd0;

    if (phase_r == PH_NEED) begin
      // wait for the level size pipeline to settle
      needst_nxt = needst_r + 2'd1;
      if (needst_r == 2'd3) phase_nxt = PH_INDEX;
      fin = 1'b0;
    end else if (go) begin
      if (phase_r != PH_HALT) offs_nxt = offs_r + 33'd1;
      case (phase_r)
        PH_HEADER: begin
          hb = hb_r;
          raw = wasm_r | (32'(byte_in) << {hb[1:0], 3'b000});
          wasm_nxt = raw;
          hb_nxt = hb_r + 6'd1;
          if (hb[1:0] == 2'd3) begin
            wasm_nxt = '0;
            w = ktx_swap(raw, be_r);
            case (hb[5:2])
              4'd0: be_nxt = (raw == 32'h01020304);
              4'd1: gt_nxt = w;
              4'd3: gf_nxt = w;
              4'd4: gi_nxt = w;
              4'd6: bw_nxt = (w > 32'h1FFFF) ? 17'h1FFFF : w[16:0];
              4'd7: bh_nxt = (w > 32'h1FFFF) ? 17'h1FFFF : w[16:0];
              4'd8, 4'd9, 4'd10: if (w > 32'd1) n2d_nxt = 1'b1;
              4'd11: mips_nxt = (w > 32'd63) ? 6'd63 : w[5:0];
              4'd12: kvl_nxt = w;
              default: ;
            endcase
          end
          if (hb == 6'd51) begin
            bh = (bh_nxt == 17'd0) ? 17'd1 : bh_nxt;
            mc = (mips_nxt == 6'd0) ? 6'd1 : mips_nxt;
            bh_nxt = bh;
            mips_nxt = mc;
            cls = ktx_classify(gt_r, gf_r, gi_r);
            rr = '0;  rr.kind = K_ERROR;
            if (file_length < 32'd64) begin
              rr.error_code = E_SHORT;  n = 2'd1;
            end else if (bw_r == 17'd0) begin
              rr.error_code = E_ZERO;  n = 2'd1;
            end else if (n2d_nxt) begin
              rr.error_code = E_NOT2D;  n = 2'd1;
            end else if ({1'b0, bw_r} > DIM_LIM || {1'b0, bh} > DIM_LIM || mc > LVL_LIM) begin
              rr.error_code = E_IMPL;  n = 2'd1;
            end else if (!cls.ok) begin
              rr.error_code = E_UNSUP;  n = 2'd1;
            end else begin
              mode_nxt = cls.mode;
              bc_nxt = cls.bc;
              lvl_nxt = '0;
              if (kvl_nxt != 32'd0) begin
                skip_nxt = {1'b0, kvl_nxt};
                phase_nxt = PH_SKIP;
              end else if (offs_nxt + 33'd4 > {1'b0, file_length}) begin
                rr.error_code = E_ICUT;  n = 2'd1;
              end else begin
                phase_nxt = PH_NEED;  needst_nxt = '0;  wb_nxt = '0;  wasm_nxt = '0;
              end
            end
            if (n != 2'd0) phase_nxt = PH_HALT;
            pr.r0 = rr;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 33'd1;
          if (skip_r == 33'd1) begin
            if (offs_nxt + 33'd4 > {1'b0, file_length}) begin
              rr = '0;  rr.kind = K_ERROR;  rr.error_code = E_ICUT;  n = 2'd1;
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_NEED;  needst_nxt = '0;  wb_nxt = '0;  wasm_nxt = '0;
            end
            pr.r0 = rr;
          end
        end
        PH_INDEX: begin
          raw = wasm_r | (32'(byte_in) << {wb_r, 3'b000});
          wasm_nxt = raw;
          wb_nxt = wb_r + 2'd1;
          if (wb_r == 2'd3) begin
            wasm_nxt = '0;
            w = ktx_swap(raw, be_r);
            isz_nxt = w;
            if (offs_nxt + {1'b0, w} > {1'b0, file_length}) begin
              rr = '0;  rr.kind = K_ERROR;  rr.error_code = E_DCUT;  n = 2'd1;
              phase_nxt = PH_HALT;
              pr.r0 = rr;
            end else if (need_r > {4'b0, w}) begin
              rr = '0;  rr.kind = K_ERROR;  rr.error_code = E_LSHORT;  n = 2'd1;
              phase_nxt = PH_HALT;
              pr.r0 = rr;
            end else begin
              rr.kind = K_DESC;  pr.r0 = rr;  n = 2'd1;
              used = (need_r != 36'd0) ? need_r[31:0] : w;
              left_nxt = used;
              rpos_nxt = '0;  pk_nxt = '0;  pix_nxt = '0;
              phase_nxt = PH_DATA;
              if (used == 32'd0) begin
                tmp = 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          if (mode_r <= M_RGB8) begin
            if (rpos_r < act_r) begin
              p = pix_r | (32'(byte_in) << {pk_r, 3'b000});
              pix_nxt = p;
              if ((mode_r == M_RGB8 && pk_r == 2'd2) || pk_r == 2'd3) begin
                if (mode_r == M_BGRA8) p = {p[31:24], p[7:0], p[15:8], p[23:16]};
                else if (mode_r == M_RGB8) p = p | 32'hFF000000;
                rr.kind = K_PIXEL;  rr.data_word = p;  pr.r0 = rr;  n = 2'd1;
                pix_nxt = '0;  pk_nxt = '0;
              end else begin
                pk_nxt = pk_r + 2'd1;
              end
            end
            rpos_nxt = rpos_r + 19'd1;
            if (rpos_r + 19'd1 >= stride_r) rpos_nxt = '0;
          end else begin
            raw = wasm_r | (32'(byte_in) << {wb_r, 3'b000});
            wasm_nxt = raw;
            wb_nxt = wb_r + 2'd1;
            if (wb_r == 2'd3 || left_r == 32'd1) begin
              rr.kind = K_RAW;  rr.data_word = raw;  pr.r0 = rr;  n = 2'd1;
              wasm_nxt = '0;  wb_nxt = '0;
            end
          end
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) tmp = 1'b1;
        end
        default: ;
      endcase

      // level finished
      if (tmp) begin
        rr = '0;
        if ({1'b0, lvl_r} + 6'd1 >= mips_r) begin
          rr.kind = K_DONE;
          phase_nxt = PH_HALT;
          if (n == 2'd0) pr.r0 = rr; else pr.r1 = rr;
          n = n + 2'd1;
        end else begin
          used = (need_r != 36'd0) ? need_r[31:0] : isz_r;
          if (phase_r == PH_INDEX) used = (need_r != 36'd0) ? need_r[31:0] : isz_nxt;
          w = (phase_r == PH_INDEX) ? isz_nxt : isz_r;
          pad = 2'd3 - 2'(w + 32'd3);
          lvl_nxt = lvl_r + 5'd1;
          skip_nxt = {1'b0, w - used} + 33'(pad);
          if (skip_nxt != 33'd0) begin
            phase_nxt = PH_SKIP;
          end else if (offs_nxt + 33'd4 > {1'b0, file_length}) begin
            rr.kind = K_ERROR;  rr.error_code = E_ICUT;
            phase_nxt = PH_HALT;
            rr.level_index = '0;
            if (n == 2'd0) pr.r0 = rr; else pr.r1 = rr;
            n = n + 2'd1;
          end else begin
            phase_nxt = PH_NEED;  needst_nxt = '0;  wb_nxt = '0;  wasm_nxt = '0;
          end
        end
      end

      if (end_of_file) begin
        if (phase_nxt != PH_HALT) begin
          rr = '0;  rr.kind = K_ERROR;
          rr.error_code = (phase_r == PH_HEADER && phase_nxt == PH_HEADER) ? E_SHORT :
                          (phase_nxt == PH_DATA) ? E_DCUT : E_ICUT;
          if (n == 2'd0) pr.r0 = rr; else pr.r1 = rr;
          n = n + 2'd1;
        end
        fin = 1'b1;
      end
      if (n == 2'd1) pr.r0.last = 1'b1;
      if (n == 2'd2) pr.r1.last = 1'b1;
      pr.v0 = (n != 2'd0);
      pr.v1 = (n == 2'd2);
    end

    if (fin) begin
      phase_nxt = PH_HEADER;  offs_nxt = 33'd12;  wasm_nxt = '0;  hb_nxt = '0;
      wb_nxt = '0;  be_nxt = 1'b0;  gt_nxt = '0;  gf_nxt = '0;  gi_nxt = '0;
      bw_nxt = '0;  bh_nxt = '0;  mips_nxt = '0;  kvl_nxt = '0;  n2d_nxt = 1'b0;
      lvl_nxt = '0;  mode_nxt = '0;  bc_nxt = '0;  isz_nxt = '0;  left_nxt = '0;
      rpos_nxt = '0;  pk_nxt = '0;  pix_nxt = '0;  skip_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;  offs_r <= 33'd12;  wasm_r <= '0;  hb_r <= '0;
      wb_r <= '0;  be_r <= 1'b0;  gt_r <= '0;  gf_r <= '0;  gi_r <= '0;
      bw_r <= '0;  bh_r <= '0;  mips_r <= '0;  kvl_r <= '0;  n2d_r <= 1'b0;
      lvl_r <= '0;  mode_r <= '0;  bc_r <= '0;  isz_r <= '0;  left_r <= '0;
      rpos_r <= '0;  pk_r <= '0;  pix_r <= '0;  skip_r <= '0;  needst_r <= '0;
    end else begin
      phase_r <= phase_nxt;  offs_r <= offs_nxt;  wasm_r <= wasm_nxt;  hb_r <= hb_nxt;
      wb_r <= wb_nxt;  be_r <= be_nxt;  gt_r <= gt_nxt;  gf_r <= gf_nxt;  gi_r <= gi_nxt;
      bw_r <= bw_nxt;  bh_r <= bh_nxt;  mips_r <= mips_nxt;  kvl_r <= kvl_nxt;
      n2d_r <= n2d_nxt;  lvl_r <= lvl_nxt;  mode_r <= mode_nxt;  bc_r <= bc_nxt;
      isz_r <= isz_nxt;  left_r <= left_nxt;  rpos_r <= rpos_nxt;  pk_r <= pk_nxt;
      pix_r <= pix_nxt;  skip_r <= skip_nxt;  needst_r <= needst_nxt;
    end
  end

endmodule

/* rtl/ktx_back.sv */
// ----------------------------------------------------------------------------
// ktx_back: result queue and output stage
// buffers result pairs and, while out_stall is low, hands results out one per cycle
// ----------------------------------------------------------------------------
module ktx_back import ktx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ktx_pair_t pair,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output ktx_res_t  res
);

  ktx_pair_t       q_r [QDEPTH];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QAW:0]    cnt_r;
  logic            half_r;

  logic            pop;
  ktx_pair_t       head;

  assign head      = q_r[rp_r];
  assign out_valid = (cnt_r != '0);
  assign res       = half_r ? head.r1 : head.r0;
  assign room      = (cnt_r < (QAW+1)'(QDEPTH - 1));
  assign pop       = out_valid && !out_stall && (half_r || !head.v1);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;  rp_r <= '0;  cnt_r <= '0;  half_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
      if (out_valid && !out_stall) half_r <= head.v1 && !half_r;
    end
  end

endmodule

/* rtl/ktx1_container_parser_unit.sv */
// ----------------------------------------------------------------------------
// ktx1_container_parser_unit: ktx1 texture container byte parser
// ----------------------------------------------------------------------------
// usage: write cfg_file_length while idle, then stream the file bytes that
// follow the 12-byte identifier on in_byte_in, with in_end_of_file on the
// last byte. items move when valid is high and stall is low.
// results appear on out_* as descriptors, pixels, raw words, done or error.
// a result enters the result queue when its byte is taken.
// bytes move at one byte per cycle while in_stall is low; before each level
// size word the parser waits while the level size multiplier settles.
// a byte giving two results hands them out one after the other.
// a small result queue parts parser and output, so in_stall rises only
// when the queue is near full or during the level size wait.
// reset (rst_n low, synchronous) clears the parser and empties the queue.
// when out_stall is high results wait in the queue, unchanged on the port.
// ----------------------------------------------------------------------------
module ktx1_container_parser_unit import ktx_pkg::*; #(
  parameter int unsigned MAX_LEVELS    = DEF_MAX_LEVELS,
  parameter int unsigned MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_file_length,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_level_index,
  output logic [16:0] out_level_width,
  output logic [16:0] out_level_height,
  output logic [2:0]  out_mode,
  output logic [2:0]  out_bc_kind,
  output logic [31:0] out_data_word,
  output logic [2:0]  out_error_code,
  output logic        out_last
);

  logic [31:0] flen_r;
  logic        busy, room, go;
  ktx_pair_t   pair;
  ktx_res_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) flen_r <= '0;
    else if (cfg_we) flen_r <= cfg_file_length;
  end

  assign in_stall = busy || !room;
  assign go = in_valid && !in_stall;

  ktx_front #(.MAX_LEVELS(MAX_LEVELS), .MAX_DIMENSION(MAX_DIMENSION)) u_front (
    .clk(clk), .rst_n(rst_n), .file_length(flen_r), .go(go),
    .byte_in(in_byte_in), .end_of_file(in_end_of_file), .busy(busy), .pair(pair)
  );

  ktx_back u_back (
    .clk(clk), .rst_n(rst_n), .push(go && pair.v0), .pair(pair), .room(room),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign out_kind         = res.kind;
  assign out_level_index  = res.level_index;
  assign out_level_width  = res.level_width;
  assign out_level_height = res.level_height;
  assign out_mode         = res.mode;
  assign out_bc_kind      = res.bc_kind;
  assign out_data_word    = res.data_word;
  assign out_error_code   = res.error_code;
  assign out_last         = res.last;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of ktx1_container_parser_unit
// builds ktx1 byte streams (good files in every format, header faults, cut
// files, noise), runs them through the parser with random idling on both
// sides and checks every result against an in-bench parser of its own
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ktx_pkg::*;

  localparam int LIMIT = 3000000;

  typedef enum int {PS_HEADER, PS_SKIP, PS_SIZE, PS_LEVEL, PS_STOP} parse_state_e;

  typedef struct {
    bit          be;
    int          fmt;
    int unsigned w, h, d, a, fc, mips, kv;
    int          delta;
  } file_spec_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_file_length;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_in;
  logic        in_end_of_file;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [4:0]  out_level_index;
  logic [16:0] out_level_width;
  logic [16:0] out_level_height;
  logic [2:0]  out_mode;
  logic [2:0]  out_bc_kind;
  logic [31:0] out_data_word;
  logic [2:0]  out_error_code;
  logic        out_last;

  ktx1_container_parser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_file_length(cfg_file_length),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte_in(in_byte_in), .in_end_of_file(in_end_of_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_level_index(out_level_index),
    .out_level_width(out_level_width), .out_level_height(out_level_height),
    .out_mode(out_mode), .out_bc_kind(out_bc_kind),
    .out_data_word(out_data_word), .out_error_code(out_error_code),
    .out_last(out_last)
  );

  ktx_res_t    expected_q[$];
  ktx_res_t    byte_results[$];
  int          errors = 0;
  int          cycles = 0;
  int          hold_len = 0;
  bit          steady_tx = 0;
  bit          steady_rx = 0;
  byte unsigned file_q[$];

  // format table: type, format, internal, mode (-1 unsupported), bc kind
  int unsigned ft_t[27] = '{32'h1401, 32'h1401, 32'h1401, 32'h1401, 32'h1401,
                            32'h140B, 32'h140B, 32'h1406, 0, 0, 0, 0, 0, 0, 0, 0,
                            0, 0, 0, 0, 0, 0, 0, 0, 32'h1401, 0, 32'h1406};
  int unsigned ft_f[27] = '{32'h1908, 0, 32'h80E1, 32'h1907, 0, 32'h1908, 0, 32'h1908,
                            0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                            32'h1234, 0, 0};
  int unsigned ft_i[27] = '{32'h8058, 32'h8C43, 0, 32'h8051, 32'h8C41, 32'h881A,
                            32'h881A, 32'h8814, 32'h8E8C, 32'h8E8D, 32'h8E8E, 32'h8E8F,
                            32'h83F0, 32'h83F1, 32'h8C4C, 32'h8C4D, 32'h83F2, 32'h8C4E,
                            32'h83F3, 32'h8C4F, 32'h8DBB, 32'h8DBC, 32'h8DBD, 32'h8DBE,
                            0, 32'h1234, 32'h8814};
  int          ft_m[27] = '{0, 0, 1, 2, 2, 3, 3, 4, 5, 5, 6, 6, 7, 7, 7, 7, 7, 7, 7, 7,
                            7, 7, 7, 7, -1, -1, 4};
  int unsigned ft_b[27] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 2, 2,
                            3, 3, 4, 4, 0, 0, 0};

  // ---------------- parser state ----------------
  int unsigned       flen;
  parse_state_e      pst;
  longint unsigned   pos;
  int unsigned       asm_word, nbytes;
  bit                big_end, not2d;
  int unsigned       gl_t, gl_f, gl_i;
  int unsigned       bw, bh, mips, kvlen;
  int unsigned       lvl, lmode, lbc;
  int unsigned       isize, left, rowpos, pix;
  longint unsigned   skip_left;

  function automatic int unsigned dim_at(int unsigned base, int unsigned l);
    int unsigned v;
    v = l < 32 ? base >> l : 0;
    return v != 0 ? v : 1;
  endfunction

  function automatic longint unsigned bytes_needed(int m, int unsigned bc,
                                                    longint unsigned w, longint unsigned h);
    case (m)
      M_RGBA8, M_BGRA8: return ((w * 4 + 3) & ~64'd3) * h;
      M_RGB8:           return ((w * 3 + 3) & ~64'd3) * h;
      M_F16:            return w * h * 8;
      M_F32:            return w * h * 16;
      M_BCDEC:          return ((w + 3) / 4) * ((h + 3) / 4) * ((bc == 0 || bc == 3) ? 8 : 16);
      default:          return 0;
    endcase
  endfunction

  function automatic int unsigned swap_if_be(int unsigned w);
    return big_end ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
  endfunction

  function automatic longint unsigned need_now();
    return bytes_needed(lmode, lbc, dim_at(bw, lvl), dim_at(bh, lvl));
  endfunction

  task automatic emit(logic [2:0] k, logic [31:0] w, logic [2:0] e);
    ktx_res_t r;
    r = '0;
    r.kind = k;
    if (k <= K_RAW) begin
      r.level_index  = lvl[4:0];
      r.level_width  = dim_at(bw, lvl);
      r.level_height = dim_at(bh, lvl);
      r.mode         = lmode[2:0];
      r.bc_kind      = lmode == M_BCDEC ? lbc[2:0] : 3'd0;
      r.data_word    = w;
    end
    if (k == K_ERROR) begin
      r.error_code = e;
      pst = PS_STOP;
    end
    if (k == K_DONE) pst = PS_STOP;
    byte_results.push_back(r);
  endtask

  function automatic int pick_mode(output int unsigned bc);
    bc = 0;
    if (gl_t == 0) begin
      case (gl_i)
        32'h83F0, 32'h83F1, 32'h8C4C, 32'h8C4D: return M_BCDEC;
        32'h83F2, 32'h8C4E: begin bc = 1; return M_BCDEC; end
        32'h83F3, 32'h8C4F: begin bc = 2; return M_BCDEC; end
        32'h8DBB, 32'h8DBC: begin bc = 3; return M_BCDEC; end
        32'h8DBD, 32'h8DBE: begin bc = 4; return M_BCDEC; end
        32'h8E8C, 32'h8E8D: return M_BC7;
        32'h8E8E, 32'h8E8F: return M_BC6H;
        default: return -1;
      endcase
    end
    if (gl_t == 32'h1401) begin
      if (gl_f == 32'h80E1) return M_BGRA8;
      if (gl_f == 32'h1908 || gl_i == 32'h8058 || gl_i == 32'h8C43) return M_RGBA8;
      if (gl_f == 32'h1907 || gl_i == 32'h8051 || gl_i == 32'h8C41) return M_RGB8;
    end else if (gl_t == 32'h140B && (gl_f == 32'h1908 || gl_i == 32'h881A)) begin
      return M_F16;
    end else if (gl_t == 32'h1406 && (gl_f == 32'h1908 || gl_i == 32'h8814)) begin
      return M_F32;
    end
    return -1;
  endfunction

  task automatic enter_size();
    if (pos + 4 > flen) begin
      emit(K_ERROR, 0, E_ICUT);
    end else begin
      pst = PS_SIZE;
      nbytes = 0;
      asm_word = 0;
    end
  endtask

  task automatic skip_bytes(longint unsigned count);
    if (count == 0) begin
      enter_size();
    end else begin
      skip_left = count;
      pst = PS_SKIP;
    end
  endtask

  task automatic header_word(int unsigned idx, int unsigned raw);
    int unsigned w;
    w = swap_if_be(raw);
    case (idx)
      0: big_end = raw == 32'h01020304;
      1: gl_t = w;
      3: gl_f = w;
      4: gl_i = w;
      6: bw = w > 32'h1FFFF ? 32'h1FFFF : w;
      7: bh = w > 32'h1FFFF ? 32'h1FFFF : w;
      8, 9, 10: if (w > 1) not2d = 1;
      11: mips = w > 63 ? 63 : w;
      12: kvlen = w;
      default: ;
    endcase
  endtask

  task automatic header_done();
    int          m;
    int unsigned bc;
    if (flen < 64) begin emit(K_ERROR, 0, E_SHORT); return; end
    if (bw == 0) begin emit(K_ERROR, 0, E_ZERO); return; end
    if (bh == 0) bh = 1;
    if (not2d) begin emit(K_ERROR, 0, E_NOT2D); return; end
    if (mips == 0) mips = 1;
    if (bw > 65536 || bh > 65536 || mips > 24) begin emit(K_ERROR, 0, E_IMPL); return; end
    m = pick_mode(bc);
    lbc = bc;
    if (m < 0) begin
      lbc = 0;
      emit(K_ERROR, 0, E_UNSUP);
      return;
    end
    lmode = m;
    lvl = 0;
    skip_bytes(kvlen);
  endtask

  task automatic level_finished();
    longint unsigned need, used;
    int unsigned     pad;
    if (lvl + 1 >= mips) begin
      lvl++;
      emit(K_DONE, 0, 0);
      return;
    end
    need = need_now();
    used = need != 0 ? need : isize;
    pad = 3 - ((isize + 3) & 3);
    lvl++;
    skip_bytes((longint'(isize) - used) + pad);
  endtask

  task automatic size_word_done();
    longint unsigned need;
    isize = swap_if_be(asm_word);
    asm_word = 0;
    if (pos + isize > flen) begin emit(K_ERROR, 0, E_DCUT); return; end
    need = need_now();
    if (need > isize) begin emit(K_ERROR, 0, E_LSHORT); return; end
    emit(K_DESC, 0, 0);
    left = need != 0 ? need[31:0] : isize;
    rowpos = 0;
    pix = 0;
    nbytes = 0;
    pst = PS_LEVEL;
    if (left == 0) level_finished();
  endtask

  task automatic level_byte(int unsigned b);
    int unsigned bpp, active, stride, k, p;
    if (lmode <= M_RGB8) begin
      bpp = lmode == M_RGB8 ? 3 : 4;
      active = dim_at(bw, lvl) * bpp;
      stride = (active + 3) & ~32'd3;
      if (rowpos < active) begin
        k = rowpos % bpp;
        pix |= b << (8 * k);
        if (k == bpp - 1) begin
          p = pix;
          if (lmode == M_BGRA8)
            p = (p & 32'hFF00FF00) | ((p >> 16) & 32'hFF) | ((p & 32'hFF) << 16);
          else if (lmode == M_RGB8)
            p |= 32'hFF000000;
          emit(K_PIXEL, p, 0);
          pix = 0;
        end
      end
      rowpos++;
      if (rowpos >= stride) rowpos = 0;
    end else begin
      asm_word |= b << (8 * (nbytes & 3));
      nbytes++;
      if (nbytes >= 4 || left == 1) begin
        emit(K_RAW, asm_word, 0);
        asm_word = 0;
        nbytes = 0;
      end
    end
    left--;
    if (left == 0) level_finished();
  endtask

  task automatic clear_parse();
    pst = PS_HEADER;
    pos = 12;
    asm_word = 0; nbytes = 0;
    big_end = 0; not2d = 0;
    gl_t = 0; gl_f = 0; gl_i = 0;
    bw = 0; bh = 0; mips = 0; kvlen = 0;
    lvl = 0; lmode = 0; lbc = 0;
    isize = 0; left = 0; rowpos = 0; pix = 0;
    skip_left = 0;
  endtask

  task automatic parse_byte(int unsigned b, bit eof);
    int unsigned hb;
    byte_results.delete();
    if (pst != PS_STOP) pos++;
    case (pst)
      PS_HEADER: begin
        hb = pos - 13;
        asm_word |= b << (8 * (hb & 3));
        if ((hb & 3) == 3) begin
          header_word(hb >> 2, asm_word);
          asm_word = 0;
        end
        if (hb == 51) header_done();
      end
      PS_SKIP: begin
        skip_left--;
        if (skip_left == 0) enter_size();
      end
      PS_SIZE: begin
        asm_word |= b << (8 * (nbytes & 3));
        nbytes++;
        if (nbytes >= 4) size_word_done();
      end
      PS_LEVEL: level_byte(b);
      default: ;
    endcase
    if (eof) begin
      if (pst != PS_STOP)
        emit(K_ERROR, 0, pst == PS_HEADER ? E_SHORT : (pst == PS_LEVEL ? E_DCUT : E_ICUT));
      clear_parse();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[j]) expected_q.push_back(byte_results[j]);
  endtask

  // ---------------- clock, timeout, receiver, checker ----------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        n = steady_rx ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ktx_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual kind %0d", $time, out_kind);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("kind", e.kind, out_kind);
        check_field("level_index", e.level_index, out_level_index);
        check_field("level_width", e.level_width, out_level_width);
        check_field("level_height", e.level_height, out_level_height);
        check_field("mode", e.mode, out_mode);
        check_field("bc_kind", e.bc_kind, out_bc_kind);
        check_field("data_word", e.data_word, out_data_word);
        check_field("error_code", e.error_code, out_error_code);
        check_field("last", e.last, out_last);
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_byte(byte unsigned b, bit eof);
    int n;
    n = steady_tx ? 0 : $urandom_range(0, 9);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    parse_byte(b, eof);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    // size-word settle and queue flush
    repeat (12) @(posedge clk);
  endtask

  task automatic write_length(int unsigned v);
    cfg_we <= 1'b1;
    cfg_file_length <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    flen = v;
  endtask

  task automatic stream_file(int unsigned length);
    wait_idle();
    write_length(length);
    foreach (file_q[j]) send_byte(file_q[j], j == file_q.size() - 1);
  endtask

  task automatic push_word(bit be, int unsigned w);
    for (int j = 0; j < 4; j++)
      file_q.push_back(be ? w[8 * (3 - j) +: 8] : w[8 * j +: 8]);
  endtask

  task automatic build_file(file_spec_t s);
    int unsigned     levels;
    longint unsigned need;
    int              size;
    file_q.delete();
    push_word(s.be, 32'h04030201);
    push_word(s.be, ft_t[s.fmt]);
    push_word(s.be, 1);
    push_word(s.be, ft_f[s.fmt]);
    push_word(s.be, ft_i[s.fmt]);
    push_word(s.be, ft_i[s.fmt]);
    push_word(s.be, s.w);
    push_word(s.be, s.h);
    push_word(s.be, s.d);
    push_word(s.be, s.a);
    push_word(s.be, s.fc);
    push_word(s.be, s.mips);
    push_word(s.be, s.kv);
    repeat (s.kv) file_q.push_back($urandom_range(0, 255));
    levels = s.mips == 0 ? 1 : (s.mips > 24 ? 1 : s.mips);
    for (int l = 0; l < levels; l++) begin
      need = bytes_needed(ft_m[s.fmt], ft_b[s.fmt], dim_at(s.w, l),
                          dim_at(s.h == 0 ? 1 : s.h, l));
      size = need == 0 ? $urandom_range(0, 11) : int'(need) + s.delta;
      if (size < 0) size = 0;
      push_word(s.be, size);
      repeat (size) file_q.push_back($urandom_range(0, 255));
      repeat ((4 - size % 4) % 4) file_q.push_back(8'h00);
    end
  endtask

  function automatic file_spec_t plain_spec(int fmt, int unsigned w, int unsigned h,
                                            int unsigned mips);
    file_spec_t s;
    s.be = 0; s.fmt = fmt; s.w = w; s.h = h;
    s.d = 0; s.a = 0; s.fc = 1; s.mips = mips; s.kv = 0; s.delta = 0;
    return s;
  endfunction

  function automatic file_spec_t random_spec();
    file_spec_t s;
    s = plain_spec($urandom_range(0, 26), $urandom_range(1, 9), $urandom_range(0, 5),
                   $urandom_range(0, 4));
    s.be = $urandom_range(0, 1);
    s.kv = $urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : 0;
    s.delta = $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0;
    return s;
  endfunction

  // ---------------- tests ----------------
  task automatic test_formats();
    file_spec_t s;
    for (int f = 0; f < 27; f++) begin
      s = plain_spec(f, 3 + f % 5, 2 + f % 3, 2 + f % 2);
      s.be = f % 2;
      s.kv = f % 4;
      s.delta = f % 3;
      build_file(s);
      stream_file(12 + file_q.size());
    end
    // most mip levels on a 1x1 image, every level 1x1, length at its maximum
    s = plain_spec(0, 1, 1, 24);
    build_file(s);
    stream_file(32'hFFFFFFFF);
  endtask

  task automatic test_header_faults();
    file_spec_t s;
    s = plain_spec(0, 2, 2, 1);
    build_file(s);
    stream_file(0);
    stream_file(63);
    s = plain_spec(0, 0, 2, 1);
    build_file(s);
    stream_file(12 + file_q.size());
    for (int k = 0; k < 3; k++) begin
      s = plain_spec(3, 2, 2, 1);
      if (k == 0) s.d = 2;
      if (k == 1) s.a = 32'hFFFFFFFF;
      if (k == 2) s.fc = 6;
      build_file(s);
      stream_file(12 + file_q.size());
    end
    s = plain_spec(0, 65537, 1, 1);
    build_file(s);
    stream_file(12 + file_q.size());
    s = plain_spec(0, 1, 32'hFFFFFFFF, 1);
    build_file(s);
    stream_file(12 + file_q.size());
    s = plain_spec(0, 1, 1, 25);
    build_file(s);
    stream_file(12 + file_q.size());
    // widest image, short level size
    s = plain_spec(1, 65536, 65536, 1);
    s.delta = -int'(bytes_needed(1, 0, 65536, 65536)) + 4;
    build_file(s);
    stream_file(32'hFFFFFFFF);
  endtask

  task automatic test_cut_files();
    file_spec_t s;
    s = plain_spec(2, 5, 3, 2);
    s.kv = 6;
    build_file(s);
    stream_file(12 + 52 + 6 + 2);
    stream_file(12 + 52 + 6 + 4 + 10);
    s.delta = -2;
    build_file(s);
    stream_file(12 + file_q.size());
    s = plain_spec(7, 2, 2, 1);
    s.kv = 8;
    build_file(s);
    file_q = file_q[0:29];
    stream_file(1000);
    build_file(s);
    file_q = file_q[0:62];
    stream_file(1000);
    build_file(s);
    file_q = file_q[0:64];
    stream_file(1000);
    build_file(s);
    file_q = file_q[0:75];
    stream_file(1000);
  endtask

  task automatic test_backpressure();
    file_spec_t s;
    s = plain_spec(0, 8, 4, 2);
    build_file(s);
    wait_idle();
    write_length(12 + file_q.size());
    steady_tx = 1;
    hold_len = 300;
    foreach (file_q[j]) send_byte(file_q[j], j == file_q.size() - 1);
    steady_tx = 0;
  endtask

  task automatic test_random_files();
    file_spec_t s;
    int         total, pick;
    int unsigned length;
    total = 0;
    while (total < 2000) begin
      steady_tx = $urandom_range(0, 4) == 0;
      steady_rx = $urandom_range(0, 4) == 0;
      s = random_spec();
      pick = $urandom_range(0, 9);
      if (pick == 7) begin
        case ($urandom_range(0, 4))
          0: s.w = 0;
          1: s.d = $urandom_range(2, 3);
          2: s.mips = $urandom_range(25, 70);
          3: s.fc = 6;
          default: s.delta = -$urandom_range(1, 6);
        endcase
      end
      build_file(s);
      length = 12 + file_q.size();
      if (pick == 8) begin
        if ($urandom_range(0, 1)) file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
        else length = $urandom_range(0, length);
      end else if (pick == 9) begin
        file_q.delete();
        repeat ($urandom_range(1, 90)) file_q.push_back($urandom_range(0, 255));
        length = $urandom();
      end
      total += file_q.size();
      stream_file(length);
    end
    steady_tx = 0;
    steady_rx = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_file_length <= '0;
    in_valid <= 1'b0;
    in_byte_in <= '0;
    in_end_of_file <= 1'b0;
    flen = 0;
    clear_parse();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_formats();
    test_header_faults();
    test_cut_files();
    test_backpressure();
    test_random_files();
    wait_idle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
